// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the packet aggregator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/aspa_pkg.sv
// ----------------------------------------------------------------------------
// aspa_pkg
// Types and constants shared by the audio sample packet aggregator.
// ----------------------------------------------------------------------------
package aspa_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_PAYLOAD_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_PACKET_HEADER  = 3'd1;
    localparam logic [2:0] CFG_SAMPLE_HEADER  = 3'd2;
    localparam logic [2:0] CFG_MAX_SAMPLES    = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_DUR     = 3'd4;

    // Configuration reset values
    localparam logic [15:0] RST_PAYLOAD_LIMIT = 16'd1460;
    localparam logic [7:0]  RST_PACKET_HEADER = 8'd0;
    localparam logic [7:0]  RST_SAMPLE_HEADER = 8'd0;
    localparam logic [7:0]  RST_MAX_SAMPLES   = 8'd1;
    localparam logic [31:0] RST_SAMPLE_DUR    = 32'd1024;

    // Result kinds
    localparam logic KIND_PACKET   = 1'b0;
    localparam logic KIND_FRAGMENT = 1'b1;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [19:0] sample_size;
        logic        end_of_track;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [31:0] first_sample_id;
        logic [7:0]  sample_count;
        logic [19:0] fragment_bytes;
        logic [39:0] duration;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] payload_limit;
        logic [7:0]  packet_header_bytes;
        logic [7:0]  sample_header_bytes;
        logic [7:0]  max_samples;
        logic [31:0] sample_duration;
    } t_cfg;

    // Up to two results from one item; a is always older than b
    typedef struct packed {
        logic      a_valid;
        logic      b_valid;
        t_out_item a;
        t_out_item b;
    } t_push;

endpackage

// File: hdl/aspa_cfg.sv
// ----------------------------------------------------------------------------
// aspa_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module aspa_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output aspa_pkg::t_cfg    o_cfg
);

    aspa_pkg::t_cfg r_cfg;
    logic           wr_en;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;
    assign wr_en       = i_cfg_valid && o_cfg_ready;
    assign o_cfg       = r_cfg;

    // Register update; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_limit       <= aspa_pkg::RST_PAYLOAD_LIMIT;
            r_cfg.packet_header_bytes <= aspa_pkg::RST_PACKET_HEADER;
            r_cfg.sample_header_bytes <= aspa_pkg::RST_SAMPLE_HEADER;
            r_cfg.max_samples         <= aspa_pkg::RST_MAX_SAMPLES;
            r_cfg.sample_duration     <= aspa_pkg::RST_SAMPLE_DUR;
        end else if (wr_en) begin
            unique case (i_cfg_index)
                aspa_pkg::CFG_PAYLOAD_LIMIT: begin
                    r_cfg.payload_limit <= i_cfg_data[15:0];
                end
                aspa_pkg::CFG_PACKET_HEADER: begin
                    r_cfg.packet_header_bytes <= i_cfg_data[7:0];
                end
                aspa_pkg::CFG_SAMPLE_HEADER: begin
                    r_cfg.sample_header_bytes <= i_cfg_data[7:0];
                end
                aspa_pkg::CFG_MAX_SAMPLES: begin
                    r_cfg.max_samples <= i_cfg_data[7:0];
                end
                aspa_pkg::CFG_SAMPLE_DUR: begin
                    r_cfg.sample_duration <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hdl/aspa_core.sv
// ----------------------------------------------------------------------------
// aspa_core
// Input register, packet state and the single-pass packing decision.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aspa_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  aspa_pkg::t_in_item i_in_data,
    input  aspa_pkg::t_cfg     i_cfg,
    input  logic               i_room,
    output aspa_pkg::t_push    o_push
);

    // Input register
    logic               r_in_valid;
    aspa_pkg::t_in_item r_in;

    // Open packet state
    logic [15:0] r_bytes, n_bytes;
    logic [7:0]  r_held, n_held;
    logic [31:0] r_first, n_first;
    logic [31:0] r_next, n_next;

    logic        fire, accept;
    logic [20:0] need;
    logic [15:0] base, base1;
    logic [21:0] sum0, sum1;
    logic        close_cond, do_close, fits, flush;
    logic [7:0]  held1, held2;
    logic [31:0] first2;
    logic [39:0] prod, flush_dur;

    // Item moves on when the queue can take two results
    assign fire       = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // Packing decision
    assign prod = 40'(r_held) * 40'(i_cfg.sample_duration);

    always_comb begin
        need  = 21'(r_in.sample_size) + 21'(i_cfg.sample_header_bytes);
        base  = (r_held != 8'd0) ? r_bytes : 16'(i_cfg.packet_header_bytes);
        sum0  = 22'(base) + 22'(need);
        close_cond = (r_held >= i_cfg.max_samples) ||
                     (sum0 > 22'(i_cfg.payload_limit));
        do_close = close_cond && (r_held != 8'd0);
        held1 = close_cond ? 8'd0 : r_held;
        base1 = close_cond ? 16'(i_cfg.packet_header_bytes) : base;
        sum1  = 22'(base1) + 22'(need);
        fits  = (sum1 <= 22'(i_cfg.payload_limit));
        held2 = fits ? held1 + 8'd1 : 8'd0;
        first2 = (fits && held1 == 8'd0) ? r_next : r_first;
        flush = r_in.end_of_track && fits;
        flush_dur = close_cond ? 40'(i_cfg.sample_duration)
                               : prod + 40'(i_cfg.sample_duration);

        // Next state
        n_bytes = fits ? sum1[15:0] : 16'(i_cfg.packet_header_bytes);
        n_held  = held2;
        n_first = first2;
        n_next  = r_next + 32'd1;
        if (r_in.end_of_track) begin
            n_bytes = 16'(i_cfg.packet_header_bytes);
            n_held  = 8'd0;
            n_first = 32'd1;
            n_next  = 32'd1;
        end

        // Closed packet
        o_push.a_valid           = fire && do_close;
        o_push.a.kind            = aspa_pkg::KIND_PACKET;
        o_push.a.first_sample_id = r_first;
        o_push.a.sample_count    = r_held;
        o_push.a.fragment_bytes  = 20'd0;
        o_push.a.duration        = prod;
        o_push.a.last            = fits && !r_in.end_of_track;

        // Fragment request or end-of-track flush
        o_push.b_valid = fire && (!fits || flush);
        if (!fits) begin
            o_push.b.kind            = aspa_pkg::KIND_FRAGMENT;
            o_push.b.first_sample_id = r_next;
            o_push.b.sample_count    = 8'd1;
            o_push.b.fragment_bytes  = r_in.sample_size;
            o_push.b.duration        = 40'(i_cfg.sample_duration);
        end else begin
            o_push.b.kind            = aspa_pkg::KIND_PACKET;
            o_push.b.first_sample_id = first2;
            o_push.b.sample_count    = held2;
            o_push.b.fragment_bytes  = 20'd0;
            o_push.b.duration        = flush_dur;
        end
        o_push.b.last = 1'b1;
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= 16'd0;
            r_held  <= 8'd0;
            r_first <= 32'd1;
            r_next  <= 32'd1;
        end else if (fire) begin
            r_bytes <= n_bytes;
            r_held  <= n_held;
            r_first <= n_first;
            r_next  <= n_next;
        end
    end

    `ASSERT_NEXT(a_eot_restart, i_clk, i_rst_n, fire && r_in.end_of_track,
        r_next == 32'd1 && r_held == 8'd0, "numbering not restarted after end of track")
    `ASSERT_NEXT(a_id_step, i_clk, i_rst_n, fire && !r_in.end_of_track,
        r_next == $past(r_next) + 32'd1, "sample id did not advance by one")
    `ASSERT_IMPL(a_one_open, i_clk, i_rst_n, o_push.a_valid && !o_push.b_valid,
        held2 != 8'd0, "closed packet marked last with no sample taken")

endmodule

// File: hdl/aspa_queue.sv
// ----------------------------------------------------------------------------
// aspa_queue
// Result queue: up to two results in a cycle, one out a cycle unless stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aspa_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aspa_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aspa_pkg::t_out_item o_out_data
);

    aspa_pkg::t_out_item r_mem [aspa_pkg::QDEPTH];

    logic [aspa_pkg::QPTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [aspa_pkg::QCNT_W-1:0] r_count, n_count;
    logic [aspa_pkg::QCNT_W-1:0] push_n;
    logic                        pop;

    // Room for a full two-result transfer
    assign o_room      = r_count <= aspa_pkg::QCNT_W'(aspa_pkg::QDEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_mem[r_rd];
    assign pop         = o_out_valid && !i_out_stall;

    always_comb begin
        push_n  = aspa_pkg::QCNT_W'(i_push.a_valid) + aspa_pkg::QCNT_W'(i_push.b_valid);
        n_wr    = r_wr + push_n[aspa_pkg::QPTR_W-1:0];
        n_rd    = pop ? r_rd + aspa_pkg::QPTR_W'(1) : r_rd;
        n_count = r_count + push_n - aspa_pkg::QCNT_W'(pop);
    end

    // Storage; b lands after a, or in a's place when a is absent
    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr] <= i_push.a;
            if (i_push.b_valid) begin
                r_mem[r_wr + aspa_pkg::QPTR_W'(1)] <= i_push.b;
            end
        end else if (i_push.b_valid) begin
            r_mem[r_wr] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n,
        r_count <= aspa_pkg::QCNT_W'(aspa_pkg::QDEPTH), "result queue overfilled")
    `ASSERT_IMPL(a_push_room, i_clk, i_rst_n, i_push.a_valid || i_push.b_valid,
        o_room, "results pushed without room")
    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && o_out_data == $past(o_out_data), "stalled result changed")

endmodule

// File: hdl/audio_sample_packet_aggregator.sv
// Path: an item is held in the input register until the queue has room for its results.
// One item and one result per cycle unless stalled; the queue holds four results.
// The input stalls while the queue holds more than two results, until the output drains it.
// Reset: synchronous, active low; clears state and queue, loads register defaults.
// ----------------------------------------------------------------------------
// audio_sample_packet_aggregator
// Packs audio sample sizes into payload packets and fragment requests.
// ----------------------------------------------------------------------------
module audio_sample_packet_aggregator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aspa_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aspa_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    aspa_pkg::t_cfg  cfg;
    aspa_pkg::t_push push;
    logic            room;

    // Configuration registers
    aspa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Packing decision
    aspa_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_room     (room),
        .o_push     (push)
    );

    // Result queue
    aspa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sim/tb_audio_sample_packet_aggregator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_sample_packet_aggregator
// Self-checking bench for the audio sample packet aggregator. A behavioural
// packer tracks the open packet and predicts every packet and fragment
// request. A short directed script covers register extremes, oversize
// samples, header and limit changes and end-of-track flushes. Random phases
// with new register settings follow; all but the last idle at random on both sides.
// ----------------------------------------------------------------------------
module tb_audio_sample_packet_aggregator;

    localparam int          NPHASE      = 12;
    localparam int          RX_HOLD     = 80;    // long output hold-off, in cycles
    localparam int          SETTLE      = 4;     // pipeline latency plus margin
    localparam int          END_CYCLES  = 10;
    localparam int          STALL_LIMIT = 2000;  // cycles with no transfer at all
    localparam logic [2:0]  CFG_UNUSED  = 3'd7;  // index beyond the register map

    // One line of the directed script: a register write or a sample
    typedef struct {
        bit                  is_reg;
        logic [2:0]          idx;
        logic [31:0]         val;
        aspa_pkg::t_in_item  smp;
        int                  n_typed;   // -1: results come from the packer
        aspa_pkg::t_out_item e0;
        aspa_pkg::t_out_item e1;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    aspa_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    aspa_pkg::t_out_item o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [2:0]          i_cfg_index;
    logic [31:0]         i_cfg_data;

    // Packer copy of the registers and the open packet
    logic [15:0] cf_limit;
    logic [7:0]  cf_phdr;
    logic [7:0]  cf_shdr;
    logic [7:0]  cf_max;
    logic [31:0] cf_dur;
    logic [15:0] pk_bytes;
    logic [7:0]  pk_held;
    logic [31:0] pk_first;
    logic [31:0] next_id;

    aspa_pkg::t_out_item awaited [$];     // packets and fragment requests still to come
    t_row                script [$];

    // Typed expectation for the sample now on offer
    int                  typed_n;
    aspa_pkg::t_out_item typed_r0;
    aspa_pkg::t_out_item typed_r1;

    bit idle_on;
    bit rx_hold_req;
    int errors;
    int quiet_cycles;
    int n_samples;
    int n_packets;
    int n_fragments;
    int n_writes;
    int top_count;

    audio_sample_packet_aggregator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic aspa_pkg::t_out_item mk_res(logic kind, logic [31:0] first,
                                                   logic [7:0] cnt, logic [19:0] frag,
                                                   logic [39:0] dur, logic last);
        aspa_pkg::t_out_item r;
        r.kind            = kind;
        r.first_sample_id = first;
        r.sample_count    = cnt;
        r.fragment_bytes  = frag;
        r.duration        = dur;
        r.last            = last;
        return r;
    endfunction

    function automatic aspa_pkg::t_out_item open_packet();
        return mk_res(aspa_pkg::KIND_PACKET, pk_first, pk_held, 20'd0,
                      {32'd0, pk_held} * {8'd0, cf_dur}, 1'b0);
    endfunction

    // Packer: places one sample, returns the packets/fragments it releases
    function automatic int pack_sample(input aspa_pkg::t_in_item s,
                                       output aspa_pkg::t_out_item r0,
                                       output aspa_pkg::t_out_item r1);
        aspa_pkg::t_out_item res [2];
        int unsigned         need;
        int unsigned         base;
        logic [31:0]         id;
        int                  n;
        n      = 0;
        res[0] = '0;
        res[1] = '0;
        id      = next_id;
        next_id = next_id + 32'd1;
        need = 32'(s.sample_size) + 32'(cf_shdr);
        base = (pk_held != 8'd0) ? 32'(pk_bytes) : 32'(cf_phdr);
        // close the open packet if full or the sample would overflow it
        if (pk_held >= cf_max || base + need > 32'(cf_limit)) begin
            if (pk_held != 8'd0) begin
                res[n] = open_packet();
                n++;
            end
            pk_held  = 8'd0;
            pk_bytes = 16'(cf_phdr);
            base     = 32'(cf_phdr);
        end
        // join the packet, or ask for fragmentation if even empty is too small
        if (base + need <= 32'(cf_limit)) begin
            if (pk_held == 8'd0)
                pk_first = id;
            pk_bytes = 16'(base + need);
            pk_held  = pk_held + 8'd1;
        end else begin
            res[n] = mk_res(aspa_pkg::KIND_FRAGMENT, id, 8'd1, s.sample_size,
                            {8'd0, cf_dur}, 1'b0);
            n++;
            pk_held  = 8'd0;
            pk_bytes = 16'(cf_phdr);
        end
        // end of track: flush and restart numbering
        if (s.end_of_track) begin
            if (pk_held != 8'd0) begin
                res[n] = open_packet();
                n++;
            end
            pk_held  = 8'd0;
            pk_bytes = 16'(cf_phdr);
            pk_first = 32'd1;
            next_id  = 32'd1;
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        r0 = res[0];
        r1 = res[1];
        return n;
    endfunction

    function automatic t_row reg_row(logic [2:0] idx, logic [31:0] val);
        t_row r;
        r        = '{default: '0};
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic t_row chk_row(logic [19:0] sz, logic eot, int n,
                                     aspa_pkg::t_out_item e0, aspa_pkg::t_out_item e1);
        t_row r;
        r                  = '{default: '0};
        r.smp.sample_size  = sz;
        r.smp.end_of_track = eot;
        r.n_typed          = n;
        r.e0               = e0;
        r.e1               = e1;
        return r;
    endfunction

    function automatic t_row smp_row(logic [19:0] sz, logic eot);
        return chk_row(sz, eot, -1, '0, '0);
    endfunction

    task automatic field_diff(input string f, input logic [39:0] e, input logic [39:0] a);
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, f, e, a);
        errors++;
    endtask

    task automatic check_result(input aspa_pkg::t_out_item got);
        aspa_pkg::t_out_item want;
        if (awaited.size() == 0) begin
            $display("%0t: result with nothing awaited: expected none, got %p", $time, got);
            errors++;
        end else begin
            want = awaited.pop_front();
            if (got.kind !== want.kind)
                field_diff("kind", 40'(want.kind), 40'(got.kind));
            if (got.first_sample_id !== want.first_sample_id)
                field_diff("first_sample_id", 40'(want.first_sample_id),
                           40'(got.first_sample_id));
            if (got.sample_count !== want.sample_count)
                field_diff("sample_count", 40'(want.sample_count), 40'(got.sample_count));
            if (got.fragment_bytes !== want.fragment_bytes)
                field_diff("fragment_bytes", 40'(want.fragment_bytes),
                           40'(got.fragment_bytes));
            if (got.duration !== want.duration)
                field_diff("duration", want.duration, got.duration);
            if (got.last !== want.last)
                field_diff("last", 40'(want.last), 40'(got.last));
        end
        if (got.kind === aspa_pkg::KIND_FRAGMENT) begin
            n_fragments++;
        end else begin
            n_packets++;
            if (int'(got.sample_count) > top_count)
                top_count = int'(got.sample_count);
        end
    endtask

    // Transfer monitor: register writes, prediction, result check, watchdog
    always @(posedge i_clk) begin
        aspa_pkg::t_out_item r0;
        aspa_pkg::t_out_item r1;
        int                  n;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_writes++;
                case (i_cfg_index)
                    aspa_pkg::CFG_PAYLOAD_LIMIT: cf_limit = i_cfg_data[15:0];
                    aspa_pkg::CFG_PACKET_HEADER: cf_phdr  = i_cfg_data[7:0];
                    aspa_pkg::CFG_SAMPLE_HEADER: cf_shdr  = i_cfg_data[7:0];
                    aspa_pkg::CFG_MAX_SAMPLES:   cf_max   = i_cfg_data[7:0];
                    aspa_pkg::CFG_SAMPLE_DUR:    cf_dur   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                n_samples++;
                n = pack_sample(i_in_data, r0, r1);
                if (typed_n >= 0) begin
                    if (typed_n != n || (n > 0 && r0 !== typed_r0) ||
                        (n > 1 && r1 !== typed_r1)) begin
                        $display("%0t: script row expected %0d results %p %p, packer %0d %p %p",
                                 $time, typed_n, typed_r0, typed_r1, n, r0, r1);
                        errors++;
                    end
                    n       = typed_n;
                    r0      = typed_r0;
                    r1      = typed_r1;
                    typed_n = -1;
                end
                if (n > 0)
                    awaited.push_back(r0);
                if (n > 1)
                    awaited.push_back(r1);
            end
            if (o_out_valid && !i_out_stall)
                check_result(o_out_data);
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                             $time, quiet_cycles, awaited.size());
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        int rx_left;
        rx_left     = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (RX_HOLD - 1) @(negedge i_clk);
                rx_hold_req = 1'b0;
                rx_left     = 0;
            end else if (!idle_on) begin
                i_out_stall <= 1'b0;
            end else if (rx_left > 0) begin
                rx_left--;
            end else if (i_out_stall) begin
                i_out_stall <= 1'b0;
                rx_left = $urandom_range(0, 39);
            end else begin
                i_out_stall <= 1'b1;
                rx_left = $urandom_range(0, 17);
            end
        end
    end

    // Offer one sample, optionally after an idle burst; returns on its transfer
    task automatic send_item(input aspa_pkg::t_in_item s, input int n_typed,
                             input aspa_pkg::t_out_item t0, input aspa_pkg::t_out_item t1);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 20) ? $urandom_range(1, 18) : 0;
        @(negedge i_clk);
        typed_n  = n_typed;
        typed_r0 = t0;
        typed_r1 = t1;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop offering and wait until every awaited result has arrived
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        aspa_pkg::t_in_item s;
        int                 ph;
        int                 k;
        int                 r;
        int                 lim;
        int                 phdr;
        int                 shdr;
        int                 mx;
        int                 fit;
        int                 eot_pct;
        int                 n_items;
        logic [31:0]        dur;
        logic [19:0]        sz;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_on     = 1'b1;
        rx_hold_req = 1'b0;
        typed_n     = -1;
        errors      = 0;
        quiet_cycles = 0;
        n_samples   = 0;
        n_packets   = 0;
        n_fragments = 0;
        n_writes    = 0;
        top_count   = 0;

        // packer state after reset
        cf_limit = aspa_pkg::RST_PAYLOAD_LIMIT;
        cf_phdr  = aspa_pkg::RST_PACKET_HEADER;
        cf_shdr  = aspa_pkg::RST_SAMPLE_HEADER;
        cf_max   = aspa_pkg::RST_MAX_SAMPLES;
        cf_dur   = aspa_pkg::RST_SAMPLE_DUR;
        pk_bytes = {8'd0, aspa_pkg::RST_PACKET_HEADER};
        pk_held  = 8'd0;
        pk_first = 32'd1;
        next_id  = 32'd1;

        // default registers: one sample per packet, 1460 byte limit
        script.push_back(chk_row(20'd100, 1'b0, 0, '0, '0));
        script.push_back(chk_row(20'd0, 1'b0, 1,
            mk_res(aspa_pkg::KIND_PACKET, 32'd1, 8'd1, 20'd0, 40'd1024, 1'b1), '0));
        // oversize sample right after a packet closes: two results
        script.push_back(chk_row(20'd1461, 1'b0, 2,
            mk_res(aspa_pkg::KIND_PACKET, 32'd2, 8'd1, 20'd0, 40'd1024, 1'b0),
            mk_res(aspa_pkg::KIND_FRAGMENT, 32'd3, 8'd1, 20'd1461, 40'd1024, 1'b1)));
        // exact fit, then end of track flush
        script.push_back(chk_row(20'd1460, 1'b1, 1,
            mk_res(aspa_pkg::KIND_PACKET, 32'd4, 8'd1, 20'd0, 40'd1024, 1'b1), '0));
        // numbering restarted; largest size is a lone fragment
        script.push_back(chk_row(20'hFFFFF, 1'b1, 1,
            mk_res(aspa_pkg::KIND_FRAGMENT, 32'd1, 8'd1, 20'hFFFFF, 40'd1024, 1'b1), '0));
        // small limit with both headers
        script.push_back(reg_row(aspa_pkg::CFG_PAYLOAD_LIMIT, 32'd100));
        script.push_back(reg_row(aspa_pkg::CFG_PACKET_HEADER, 32'd10));
        script.push_back(reg_row(aspa_pkg::CFG_SAMPLE_HEADER, 32'd5));
        script.push_back(reg_row(aspa_pkg::CFG_MAX_SAMPLES, 32'd3));
        script.push_back(reg_row(aspa_pkg::CFG_SAMPLE_DUR, 32'h0001_2345));
        script.push_back(smp_row(20'd20, 1'b0));
        script.push_back(smp_row(20'd20, 1'b0));
        script.push_back(smp_row(20'd40, 1'b0));
        script.push_back(smp_row(20'd0, 1'b0));
        script.push_back(smp_row(20'd30, 1'b0));
        script.push_back(smp_row(20'd200, 1'b0));
        script.push_back(smp_row(20'd5, 1'b1));
        // packet header larger than the limit: nothing fits
        script.push_back(reg_row(aspa_pkg::CFG_PAYLOAD_LIMIT, 32'd5));
        script.push_back(smp_row(20'd0, 1'b0));
        script.push_back(smp_row(20'd3, 1'b1));
        // limit and header changed under an open packet
        script.push_back(reg_row(aspa_pkg::CFG_PAYLOAD_LIMIT, 32'd1000));
        script.push_back(reg_row(aspa_pkg::CFG_MAX_SAMPLES, 32'd8));
        script.push_back(smp_row(20'd100, 1'b0));
        script.push_back(smp_row(20'd100, 1'b0));
        script.push_back(reg_row(aspa_pkg::CFG_PAYLOAD_LIMIT, 32'hABCD_0096));
        script.push_back(reg_row(aspa_pkg::CFG_PACKET_HEADER, 32'd0));
        script.push_back(smp_row(20'd0, 1'b0));
        script.push_back(smp_row(20'd7, 1'b0));
        // max samples of zero behaves as one
        script.push_back(reg_row(aspa_pkg::CFG_MAX_SAMPLES, 32'd0));
        script.push_back(smp_row(20'd1, 1'b0));
        script.push_back(smp_row(20'd1, 1'b0));
        script.push_back(smp_row(20'd1, 1'b1));
        // zero limit, widest duration, write to an unmapped index
        script.push_back(reg_row(aspa_pkg::CFG_PAYLOAD_LIMIT, 32'd0));
        script.push_back(reg_row(aspa_pkg::CFG_SAMPLE_HEADER, 32'hFFFF_FF00));
        script.push_back(reg_row(aspa_pkg::CFG_SAMPLE_DUR, 32'hFFFF_FFFF));
        script.push_back(reg_row(CFG_UNUSED, 32'hFFFF_FFFF));
        script.push_back(smp_row(20'd0, 1'b0));
        script.push_back(smp_row(20'd0, 1'b1));
        script.push_back(smp_row(20'd1, 1'b1));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed script
        for (k = 0; k < script.size(); k++) begin
            if (script[k].is_reg) begin
                wait_drain();
                write_reg(script[k].idx, script[k].val);
            end else begin
                send_item(script[k].smp, script[k].n_typed, script[k].e0, script[k].e1);
            end
        end

        // random phases, each with its own register setting
        for (ph = 0; ph < NPHASE; ph++) begin
            case (ph)
                0: begin    // every register at its top: one 255-sample packet
                    lim = 65535; phdr = 255; shdr = 255; mx = 255;
                    dur = 32'hFFFF_FFFF; eot_pct = 0; n_items = 300;
                end
                1: begin
                    lim = 0; phdr = 0; shdr = 0; mx = 0;
                    dur = 32'd0; eot_pct = 10; n_items = 60;
                end
                2: begin
                    lim = 1; phdr = 255; shdr = 255; mx = 1;
                    dur = $urandom; eot_pct = 10; n_items = 40;
                end
                default: begin
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        lim = $urandom_range(64, 3000);
                    else if (r < 8)
                        lim = $urandom_range(1, 65535);
                    else if (r == 8)
                        lim = 65535;
                    else
                        lim = $urandom_range(0, 63);
                    phdr = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255);
                    shdr = ($urandom_range(0, 2) == 0) ? 0 :
                           ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 64);
                    r  = $urandom_range(0, 9);
                    mx = (r == 0) ? 0 : (r < 7) ? $urandom_range(1, 12) : $urandom_range(13, 255);
                    dur     = $urandom;
                    eot_pct = $urandom_range(2, 10);
                    n_items = 68;
                end
            endcase

            wait_drain();
            write_reg(aspa_pkg::CFG_PAYLOAD_LIMIT, {16'($urandom), 16'(lim)});
            write_reg(aspa_pkg::CFG_PACKET_HEADER, {24'($urandom), 8'(phdr)});
            write_reg(aspa_pkg::CFG_SAMPLE_HEADER, {24'($urandom), 8'(shdr)});
            write_reg(aspa_pkg::CFG_MAX_SAMPLES, {24'($urandom), 8'(mx)});
            write_reg(aspa_pkg::CFG_SAMPLE_DUR, dur);

            idle_on = (ph != NPHASE - 1);
            if (ph == 4)
                rx_hold_req = 1'b1;    // fill the block while the output is held

            // payload room left for one sample in an empty packet
            fit = lim - phdr - shdr;
            if (fit < 0)
                fit = 0;

            for (k = 0; k < n_items; k++) begin
                if (ph == 6 && k == n_items / 2)
                    wait_drain();
                r = $urandom_range(0, 99);
                if (ph == 0)
                    sz = 20'd0;
                else if (r < 45)
                    sz = 20'($urandom_range(0, lim / 6));
                else if (r < 60)
                    sz = 20'($urandom_range(0, 3));
                else if (r < 78)
                    sz = 20'($urandom_range(fit > 24 ? fit - 24 : 0, fit + 24));
                else if (r < 93)
                    sz = 20'($urandom_range(0, 20'hFFFFF));
                else
                    sz = 20'hFFFFF;
                s.sample_size  = sz;
                s.end_of_track = ($urandom_range(0, 99) < eot_pct);
                send_item(s, -1, '0, '0);
            end
        end

        wait_drain();
        repeat (END_CYCLES) @(negedge i_clk);

        $display("Packed %0d samples over %0d register writes: %0d packets (up to %0d samples),",
                 n_samples, n_writes, n_packets, top_count);
        $display("%0d fragment requests, with a long output hold-off and a mid-stream drain; %0d errors.",
                 n_fragments, errors);
        if (errors == 0 && awaited.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
